// ===== sv/amt_pkg.sv =====
// Shared constants, types and register codes for the adaptive mean threshold unit.
package amt_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_WINDOW = 31;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int WS_W   = 5;
  localparam int OFS_W  = 9;
  localparam int DATA_W = 13;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int K_W    = $clog2(MAX_WINDOW + 1);
  localparam int KK_W   = 2 * K_W;
  localparam int CS_W   = $clog2(MAX_WINDOW * 255 + 1);
  localparam int WSUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int T_W    = PIX_W + 3;
  localparam int TP_W   = PIX_W + 1;
  localparam int PROD_W = TP_W + KK_W;
  localparam int LS_AW  = SLOT_W + COL_W;
  localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int K_TOP  = (MAX_WINDOW - 1) | 1;
  localparam int Q_DEPTH = 4;

  localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0]  FH_RESET  = FH_W'(480);
  localparam logic [WS_W-1:0]  WS_RESET  = WS_W'(21);
  localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(10);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2,
    REG_OFFSET       = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first_of_frame;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             is_foreground;
  } result_t;

  // Effective configuration, after clamping
  typedef struct packed {
    logic [K_W-1:0]          k;
    logic [K_W-1:0]          half;
    logic [FW_W-1:0]         w;
    logic [FH_W-1:0]         h;
    logic [KK_W-1:0]         kk;
    logic signed [OFS_W-1:0] offset;
  } cfg_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  col_k;
    logic              row_zero;
    logic              row_ge_k;
    logic              col_zero;
    logic              col_ge_k;
    logic              produce;
    logic [SLOT_W-1:0] slot_cur;
    logic [SLOT_W-1:0] slot_old;
    logic [SLOT_W-1:0] slot_ctr;
    logic [ROW_W-1:0]  cr;
    logic [COL_W-1:0]  cc;
  } desc_t;

endpackage

// ===== sv/amt_cfg.sv =====
// Configuration registers and clamped effective settings.
module amt_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  amt_pkg::reg_index_t          cfg_index,
  input  logic [amt_pkg::DATA_W-1:0]   cfg_data,
  output amt_pkg::cfg_t                cfg
);
  import amt_pkg::*;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [WS_W-1:0]  window_size;
  logic [OFS_W-1:0] offset;
  logic [KK_W-1:0]  kk;
  logic [K_W-1:0]   k_odd;
  logic [K_W-1:0]   k_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      window_size  <= WS_RESET;
      offset       <= OFS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        REG_WINDOW_SIZE:  window_size  <= cfg_data[WS_W-1:0];
        REG_OFFSET:       offset       <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k_odd = K_W'(window_size) | K_W'(1);
    k_eff = k_odd;
    if (k_odd < K_W'(3))
      k_eff = K_W'(3);
    else if (k_odd > K_W'(K_TOP))
      k_eff = K_W'(K_TOP);
  end

  always_ff @(posedge clk) begin
    kk <= KK_W'(k_eff) * KK_W'(k_eff);
  end

  always_comb begin
    cfg.k      = k_eff;
    cfg.half   = k_eff >> 1;
    cfg.kk     = kk;
    cfg.offset = $signed(offset);
    if (frame_width == '0)
      cfg.w = FW_W'(1);
    else if (frame_width > FW_W'(MAX_WIDTH))
      cfg.w = FW_W'(MAX_WIDTH);
    else
      cfg.w = frame_width;
    if (frame_height == '0)
      cfg.h = FH_W'(1);
    else if (frame_height > FH_W'(MAX_HEIGHT))
      cfg.h = FH_W'(MAX_HEIGHT);
    else
      cfg.h = frame_height;
  end

endmodule

// ===== sv/amt_front.sv =====
// Front end: raster position tracking and per-pixel classification.
module amt_front (
  input  logic            clk,
  input  logic            rst,
  input  amt_pkg::cfg_t   cfg,
  input  logic            push,
  input  amt_pkg::item_t  item,
  input  logic            q_full,
  output logic            q_push,
  output amt_pkg::desc_t  desc
);
  import amt_pkg::*;

  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic [SLOT_W-1:0] slot_count;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [SLOT_W-1:0] slot;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [SLOT_W:0]   slot_old_x;
  logic [SLOT_W:0]   slot_ctr_x;

  assign q_push = push && !q_full;

  always_comb begin
    row  = item.first_of_frame ? '0 : row_count;
    col  = item.first_of_frame ? '0 : col_count;
    slot = item.first_of_frame ? '0 : slot_count;

    col_inc = (COL_W+1)'(col) + (COL_W+1)'(1);
    row_inc = (ROW_W+1)'(row) + (ROW_W+1)'(1);

    // slot of an earlier row, modulo the ring of stored rows
    slot_old_x = (SLOT_W+1)'(slot) - (SLOT_W+1)'(cfg.k);
    if ((SLOT_W+1)'(slot) < (SLOT_W+1)'(cfg.k))
      slot_old_x = slot_old_x + (SLOT_W+1)'(MAX_WINDOW);
    slot_ctr_x = (SLOT_W+1)'(slot) - (SLOT_W+1)'(cfg.half);
    if ((SLOT_W+1)'(slot) < (SLOT_W+1)'(cfg.half))
      slot_ctr_x = slot_ctr_x + (SLOT_W+1)'(MAX_WINDOW);

    desc.pixel    = item.pixel;
    desc.col      = col;
    desc.col_k    = col - COL_W'(cfg.k);
    desc.row_zero = (row == '0);
    desc.row_ge_k = (row >= ROW_W'(cfg.k));
    desc.col_zero = (col == '0);
    desc.col_ge_k = (col >= COL_W'(cfg.k));
    desc.produce  = (row_inc >= (ROW_W+1)'(cfg.k)) && (col_inc >= (COL_W+1)'(cfg.k));
    desc.slot_cur = slot;
    desc.slot_old = slot_old_x[SLOT_W-1:0];
    desc.slot_ctr = slot_ctr_x[SLOT_W-1:0];
    desc.cr       = row - ROW_W'(cfg.half);
    desc.cc       = col - COL_W'(cfg.half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      slot_count <= '0;
    end else if (q_push) begin
      if (col_inc >= (COL_W+1)'(cfg.w)) begin
        col_count <= '0;
        if (row_inc >= (ROW_W+1)'(cfg.h)) begin
          row_count  <= '0;
          slot_count <= '0;
        end else begin
          row_count  <= row_inc[ROW_W-1:0];
          slot_count <= (slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
        end
      end else begin
        row_count  <= row;
        col_count  <= col_inc[COL_W-1:0];
        slot_count <= slot;
      end
    end
  end

endmodule

// ===== sv/amt_queue.sv =====
// Short descriptor queue between front and back.
module amt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  amt_pkg::desc_t  wr,
  input  logic            pop,
  output logic            empty,
  output amt_pkg::desc_t  rd
);
  import amt_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  desc_t             entries [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push)
      entries[wr_ptr] <= wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)
        count <= count + CNT_W'(1);
      else if (do_pop && !do_push)
        count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== sv/amt_back.sv =====
// Back end: line store, column sums, window sum and threshold decision.
module amt_back (
  input  logic              clk,
  input  logic              rst,
  input  amt_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  amt_pkg::desc_t    q_head,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output amt_pkg::result_t  result
);
  import amt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_SUM, S_DECIDE} state_t;

  logic [PIX_W-1:0] line_store [LS_DEPTH];
  logic [CS_W-1:0]  column_sums [MAX_WIDTH];

  state_t            state;
  desc_t             d;
  logic [CS_W-1:0]   csum;
  logic [WSUM_W-1:0] window_sum;
  logic              t_le0;
  logic [PROD_W-1:0] prod;
  logic              res_valid;
  result_t           res;

  logic [COL_W-1:0]        cs_raddr;
  logic [LS_AW-1:0]        ls_raddr;
  logic [CS_W-1:0]         cs_rdata;
  logic [PIX_W-1:0]        ls_rdata;
  logic [CS_W-1:0]         csum_next;
  logic [WSUM_W-1:0]       window_sum_next;
  logic signed [T_W-1:0]   t;
  logic                    res_load;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign res_load = (state == S_DECIDE) && (!res_valid || pop);
  assign empty    = !res_valid;
  assign result   = res;

  always_comb begin
    if (state == S_IDLE) begin
      cs_raddr = q_head.col;
      ls_raddr = {q_head.slot_old, q_head.col};
    end else begin
      cs_raddr = d.col_k;
      ls_raddr = {d.slot_ctr, d.cc};
    end

    // new column sum: drop the row leaving the window
    if (d.row_zero)
      csum_next = CS_W'(d.pixel);
    else
      csum_next = CS_W'((CS_W+1)'(cs_rdata) + (CS_W+1)'(d.pixel)
                        - (d.row_ge_k ? (CS_W+1)'(ls_rdata) : '0));

    if (d.col_zero)
      window_sum_next = WSUM_W'(csum);
    else
      window_sum_next = window_sum + WSUM_W'(csum)
                        - (d.col_ge_k ? WSUM_W'(cs_rdata) : '0);

    // background iff sum >= (centre + offset + 1) * k*k, or that factor <= 0
    t = $signed({3'b000, ls_rdata}) + T_W'(cfg.offset) + T_W'(1);
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE)
      column_sums[d.col] <= csum_next;
    cs_rdata <= column_sums[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE)
      line_store[{d.slot_cur, d.col}] <= d.pixel;
    ls_rdata <= line_store[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_load)
        res_valid <= 1'b1;
      else if (pop)
        res_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            d     <= q_head;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          csum  <= csum_next;
          state <= S_SUM;
        end
        S_SUM: begin
          window_sum <= window_sum_next;
          t_le0      <= t[T_W-1] || (t == '0);
          prod       <= PROD_W'(t[TP_W-1:0]) * PROD_W'(cfg.kk);
          state      <= d.produce ? S_DECIDE : S_IDLE;
        end
        S_DECIDE: begin
          if (res_load) begin
            res.out_row       <= d.cr;
            res.out_col       <= d.cc;
            res.is_foreground <= !(t_le0 || (PROD_W'(window_sum) >= prod));
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/adaptive_mean_threshold_unit.sv =====
// Top level of the adaptive mean threshold unit.
//
// Pixels enter in raster order on the input queue: an item is taken when push
// is high and full is low. Each interior pixel (whole window inside the frame)
// yields one transaction on the result queue carrying its row, column and
// foreground flag; border pixels yield none. A result is held while empty is
// low and leaves when pop is high.
// Configuration goes through a valid/ready write channel (always ready), and
// is to be changed only while no pixel is in flight.
// The back end takes one pixel at a time from the descriptor queue and steps
// through update and sum states, plus a decide state when it produces a
// result, spending them on accesses to the line store and the column sums.
// The front end keeps accepting pixels into the queue while the back end is busy.
// If the receiver stalls, the result register holds, the back end waits, the
// 4-entry descriptor queue fills and then full rises.
// Reset loads the default configuration and clears position counters and
// queues; line store and column sums are not cleared and need no sweep.
module adaptive_mean_threshold_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  amt_pkg::reg_index_t         cfg_index,
  input  logic [amt_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  amt_pkg::item_t              item,
  output logic                        empty,
  input  logic                        pop,
  output amt_pkg::result_t            result
);
  import amt_pkg::*;

  cfg_t  cfg;
  desc_t desc;
  desc_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;

  amt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  amt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .item   (item),
    .q_full (full),
    .q_push (q_push),
    .desc   (desc)
  );

  amt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (full),
    .wr    (desc),
    .pop   (q_pop),
    .empty (q_empty),
    .rd    (q_head)
  );

  amt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
